>>> src/cpbck_pkg.sv
// Shared types and constants for the palette blit unit.
// No dependencies.
package cpbck_pkg;

    localparam int COORD_W  = 11;   // on-screen coordinate bits (screen up to 2048)
    localparam int ADDR_W   = 18;
    localparam int COLOR_W  = 16;
    localparam int INDEX_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int PAL_DEPTH  = 256;

    localparam logic [CFG_IDX_W-1:0] REG_DEST_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_SKIP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_INDEX  = 3'd6;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    typedef struct packed {
        logic signed [11:0] dest_x;
        logic signed [11:0] dest_y;
        logic [10:0]        src_width;
        logic [10:0]        src_height;
        logic [9:0]         src_skip;
        logic               key_enable;
        logic [7:0]         key_index;
    } t_cfg;

    typedef struct packed {
        logic               we;
        logic               last;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_pix;

endpackage

>>> src/cpbck_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module cpbck_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/cpbck_addr_gen.sv
// Column/row counters, screen clipping and colour-key test for source bytes.
// Depends on cpbck_pkg.
module cpbck_addr_gen #(
    parameter int FB_WIDTH  = 480,
    parameter int FB_HEIGHT = 320
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  cpbck_pkg::t_cfg                i_cfg,
    input  logic [cpbck_pkg::INDEX_W-1:0]  i_index,
    output cpbck_pkg::t_pix                o_pix
);
    import cpbck_pkg::*;

    localparam logic [12:0] FBW = 13'(FB_WIDTH);
    localparam logic [12:0] FBH = 13'(FB_HEIGHT);

    logic [10:0] r_col, n_col;
    logic [9:0]  r_row, n_row;
    logic [10:0] w, h;
    logic [11:0] row_len;
    logic signed [13:0] x, y;
    logic on, keyed, in_image, row_end, area_end;

    always_comb begin
        if (i_cfg.src_width == 11'd0)         w = 11'd1;
        else if (i_cfg.src_width > 11'd1024)  w = 11'd1024;
        else                                  w = i_cfg.src_width;
        if (i_cfg.src_height == 11'd0)        h = 11'd1;
        else if (i_cfg.src_height > 11'd1024) h = 11'd1024;
        else                                  h = i_cfg.src_height;

        row_len  = {1'b0, w} + {2'b00, i_cfg.src_skip};
        in_image = r_col < w;

        x = {{2{i_cfg.dest_x[11]}}, i_cfg.dest_x} + $signed({3'b000, r_col});
        y = {{2{i_cfg.dest_y[11]}}, i_cfg.dest_y} + $signed({4'b0000, r_row});
        on = !x[13] && (x[12:0] < FBW) && !y[13] && (y[12:0] < FBH);
        keyed = i_cfg.key_enable && (i_index == i_cfg.key_index);

        row_end  = ({1'b0, r_col} + 12'd1) >= row_len;
        area_end = ({1'b0, r_row} + 11'd1) >= h;

        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (row_end) begin
                n_col = '0;
                n_row = area_end ? '0 : r_row + 10'd1;
            end else begin
                n_col = r_col + 11'd1;
            end
        end

        o_pix.we   = in_image && on && !keyed;
        o_pix.last = row_end && area_end;
        o_pix.x    = x[COORD_W-1:0];
        o_pix.y    = y[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

>>> src/clipped_palette_blit_chroma_key_unit.sv
// Palette blit with screen clipping and colour key: top level.
// Depends on cpbck_pkg, cpbck_ram and cpbck_addr_gen.
//
// Takes one beat per cycle while not stalled, palette loads and source
// bytes alike, and gives one result beat for each: a framebuffer write
// (address y*FB_WIDTH+x, RGB565 colour) or a no-write beat, with last on
// the final byte of the source area. A beat passes the palette RAM read,
// the address multiply and the output register. A palette load written in
// one cycle is seen by a source byte in the next. The user must write
// registers through the cfg port only while no beat is in flight; unchecked.
module clipped_palette_blit_chroma_key_unit #(
    parameter int FB_WIDTH  = 480,
    parameter int FB_HEIGHT = 320
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_entry,
    input  logic [15:0] i_entry_color,
    input  logic [7:0]  i_source_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_write_enable,
    output logic [17:0] o_fb_address,
    output logic [15:0] o_write_color,
    output logic        o_last
);
    import cpbck_pkg::*;

    localparam logic [COORD_W:0] FBW = (COORD_W+1)'(FB_WIDTH);

    t_cfg r_cfg;
    t_pix pix;

    logic accept, out_free, pal_wr, pal_rd;
    logic [COLOR_W-1:0] rdata;

    logic               r_s1_valid, r_s1_we, r_s1_last;
    logic [COORD_W-1:0] r_s1_x, r_s1_y;
    logic [2*COORD_W+1:0] addr_full;

    logic               r_out_valid, r_out_we, r_out_last;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [COLOR_W-1:0] r_out_color;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_x     <= '0;
            r_cfg.dest_y     <= '0;
            r_cfg.src_width  <= 11'd1;
            r_cfg.src_height <= 11'd1;
            r_cfg.src_skip   <= '0;
            r_cfg.key_enable <= 1'b0;
            r_cfg.key_index  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEST_X:     r_cfg.dest_x     <= i_cfg_data;
                REG_DEST_Y:     r_cfg.dest_y     <= i_cfg_data;
                REG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[10:0];
                REG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data[10:0];
                REG_SRC_SKIP:   r_cfg.src_skip   <= i_cfg_data[9:0];
                REG_KEY_ENABLE: r_cfg.key_enable <= i_cfg_data[0];
                REG_KEY_INDEX:  r_cfg.key_index  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // handshake: stage 1 only waits while the output register is held
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign pal_wr     = accept && (i_operation == OP_PALETTE);
    assign pal_rd     = accept && (i_operation == OP_PIXEL);

    cpbck_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_wr),
        .i_waddr (i_entry),
        .i_wdata (i_entry_color),
        .i_re    (pal_rd),
        .i_raddr (i_source_byte),
        .o_rdata (rdata)
    );

    cpbck_addr_gen #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_addr_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (pal_rd),
        .i_cfg   (r_cfg),
        .i_index (i_source_byte),
        .o_pix   (pix)
    );

    // stage 1: palette read in flight, coordinates held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_we   <= pal_rd && pix.we;
            r_s1_last <= pal_rd && pix.last;
            r_s1_x    <= pix.x;
            r_s1_y    <= pix.y;
        end
    end

    assign addr_full = {1'b0, r_s1_y} * FBW + {{(COORD_W+2){1'b0}}, r_s1_x};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_we    <= r_s1_we;
            r_out_last  <= r_s1_last;
            r_out_addr  <= r_s1_we ? addr_full[ADDR_W-1:0] : '0;
            r_out_color <= r_s1_we ? rdata : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_enable = r_out_we;
    assign o_fb_address   = r_out_addr;
    assign o_write_color  = r_out_color;
    assign o_last         = r_out_last;

endmodule
